@@ src/lik_pkg.sv @@
// ----------------------------------------------------------------------------
// lik_pkg
// Shared types, constants and the arctangent table for the leg IK core.
// ----------------------------------------------------------------------------
`default_nettype none

package lik_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int TAB_W        = 5;
   localparam int QUEUE_DEPTH  = 2;

   // angles are Q.30 radians
   typedef logic signed [35:0] angle_type;
   typedef logic signed [33:0] cord_type;

   localparam angle_type PI_Q30   = 36'sd3373259426;
   localparam angle_type ROUND_Q12 = 36'sd131072;

   typedef struct packed {
      logic [14:0]        coxa_offset_x;
      logic signed [15:0] coxa_offset_z;
      logic [14:0]        femur_length;
      logic [14:0]        tibia_length;
   } leg_cfg_type;

   // front to back: planar geometry of one request
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [16:0] h;
      logic signed [16:0] dz;
      logic [16:0]        l;
   } leg_item_type;

   typedef struct packed {
      logic signed [15:0] coxa_angle;
      logic signed [15:0] femur_angle;
      logic signed [15:0] tibia_angle;
      logic               out_of_reach;
   } leg_result_type;

   function automatic angle_type atan_entry(input logic [TAB_W-1:0] idx);
      angle_type v;
      case (idx)
         5'd0:    v = 36'sh03243F6A8;
         5'd1:    v = 36'sh01DAC6705;
         5'd2:    v = 36'sh00FADBAFC;
         5'd3:    v = 36'sh007F56EA6;
         5'd4:    v = 36'sh003FEAB76;
         5'd5:    v = 36'sh001FFD55B;
         5'd6:    v = 36'sh000FFFAAA;
         5'd7:    v = 36'sh0007FFF55;
         5'd8:    v = 36'sh0003FFFEA;
         5'd9:    v = 36'sh0001FFFFD;
         5'd10:   v = 36'sh0000FFFFF;
         5'd11:   v = 36'sh00007FFFF;
         5'd12:   v = 36'sh00003FFFF;
         5'd13:   v = 36'sh00001FFFF;
         5'd14:   v = 36'sh00000FFFF;
         5'd15:   v = 36'sh000007FFF;
         5'd16:   v = 36'sh000003FFF;
         5'd17:   v = 36'sh000001FFF;
         5'd18:   v = 36'sh000000FFF;
         5'd19:   v = 36'sh0000007FF;
         5'd20:   v = 36'sh0000003FF;
         5'd21:   v = 36'sh0000001FF;
         5'd22:   v = 36'sh0000000FF;
         5'd23:   v = 36'sh00000007F;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q.30 to Q4.12, round half up
   function automatic logic signed [15:0] to_q12(input angle_type a);
      angle_type s;
      s = a + ROUND_Q12;
      return s[33:18];
   endfunction

endpackage

`default_nettype wire

@@ src/lik_isqrt.sv @@
// ----------------------------------------------------------------------------
// lik_isqrt
// Floor integer square root of a 64-bit value, one result bit per cycle;
// a start is ignored while a root is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_start,
   input  wire logic [63:0] in_value,
   output logic             out_done,
   output logic [31:0]      out_root
);
   import lik_pkg::*;

   typedef enum logic [1:0] {Q_IDLE, Q_RUN, Q_DONE} state_type;

   state_type   state_ff, state_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [63:0] trial;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      trial    = res_ff + bit_ff;
      case (state_ff)
         Q_IDLE: begin
            if (in_start) begin
               rem_in   = in_value;
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               state_in = Q_RUN;
            end
         end
         Q_RUN: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = Q_DONE;
            end
         end
         Q_DONE: begin
            state_in = Q_IDLE;
         end
         default: begin
            state_in = Q_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Q_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign out_done = (state_ff == Q_DONE);
   assign out_root = res_ff[31:0];

endmodule

`default_nettype wire

@@ src/lik_cordic.sv @@
// ----------------------------------------------------------------------------
// lik_cordic
// Vectoring CORDIC atan2 in Q.30 radians with operand prescaling.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_cordic (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_start,
   input  wire lik_pkg::cord_type in_y,
   input  wire lik_pkg::cord_type in_x,
   output logic                   out_done,
   output lik_pkg::angle_type     out_angle
);
   import lik_pkg::*;

   typedef enum logic [1:0] {C_IDLE, C_NORM, C_ROT, C_DONE} state_type;

   localparam logic [33:0] LIM_29 = 34'd1 << 29;
   localparam logic [33:0] LIM_27 = 34'd1 << 27;
   localparam logic [33:0] LIM_25 = 34'd1 << 25;
   localparam logic [33:0] LIM_21 = 34'd1 << 21;
   localparam logic [33:0] LIM_13 = 34'd1 << 13;

   state_type         state_ff, state_in;
   cord_type          x_ff, x_in, y_ff, y_in;
   angle_type         z_ff, z_in;
   logic [STEP_W-1:0] i_ff, i_in;

   logic [33:0] ax, ay, mx;
   logic [4:0]  sh;
   cord_type    tx, ty;
   angle_type   at;

   always_comb begin
      ax = x_ff;
      ay = y_ff[33] ? 34'(-y_ff) : y_ff;
      mx = (ax > ay) ? ax : ay;
      // largest doubling that stays below the target window
      if (mx < LIM_13) begin
         sh = 5'd16;
      end else if (mx < LIM_21) begin
         sh = 5'd8;
      end else if (mx < LIM_25) begin
         sh = 5'd4;
      end else if (mx < LIM_27) begin
         sh = 5'd2;
      end else begin
         sh = 5'd1;
      end
      tx = x_ff >>> i_ff;
      ty = y_ff >>> i_ff;
      at = atan_entry(TAB_W'(i_ff));

      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      case (state_ff)
         C_IDLE: begin
            if (in_start) begin
               i_in = '0;
               if (in_y == '0) begin
                  z_in     = in_x[33] ? PI_Q30 : '0;
                  state_in = C_DONE;
               end else if (in_x[33]) begin
                  z_in     = in_y[33] ? -PI_Q30 : PI_Q30;
                  x_in     = -in_x;
                  y_in     = -in_y;
                  state_in = C_NORM;
               end else begin
                  z_in     = '0;
                  x_in     = in_x;
                  y_in     = in_y;
                  state_in = C_NORM;
               end
            end
         end
         C_NORM: begin
            if (mx >= LIM_29) begin
               state_in = C_ROT;
            end else begin
               x_in = x_ff <<< sh;
               y_in = y_ff <<< sh;
            end
         end
         C_ROT: begin
            if (!y_ff[33]) begin
               x_in = x_ff + ty;
               y_in = y_ff - tx;
               z_in = z_ff + at;
            end else begin
               x_in = x_ff - ty;
               y_in = y_ff + tx;
               z_in = z_ff - at;
            end
            if (i_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = C_DONE;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         C_DONE: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
   end

   assign out_done  = (state_ff == C_DONE);
   assign out_angle = z_ff;

endmodule

`default_nettype wire

@@ src/lik_queue.sv @@
// ----------------------------------------------------------------------------
// lik_queue
// Short FIFO of planar geometry items between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_push,
   input  wire lik_pkg::leg_item_type in_item,
   input  wire logic                  in_pop,
   output logic                       out_full,
   output logic                       out_empty,
   output lik_pkg::leg_item_type      out_item
);
   import lik_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   leg_item_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign out_full  = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign out_empty = (cnt_ff == '0);
   assign out_item  = mem_ff[rd_ff];
   assign do_push   = in_push && !out_full;
   assign do_pop    = in_pop && !out_empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

@@ src/lik_front.sv @@
// ----------------------------------------------------------------------------
// lik_front
// Accepts a request and reduces it to planar geometry: radial reach R,
// H = R - coxa_offset_x, dz and reach distance L.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lik_pkg::leg_cfg_type cfg,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic signed [15:0]   target_x,
   input  wire logic signed [15:0]   target_y,
   input  wire logic signed [15:0]   target_z,
   output logic                      q_push,
   output lik_pkg::leg_item_type     q_item,
   input  wire logic                 q_full
);
   import lik_pkg::*;

   typedef enum logic [2:0] {
      F_IDLE, F_SUM_R, F_ROOT_R, F_WAIT_R, F_SUM_L, F_ROOT_L, F_WAIT_L, F_PUSH
   } state_type;

   state_type          state_ff, state_in;
   logic signed [15:0] x_ff, y_ff, z_ff;
   logic signed [16:0] h_ff, h_in, dz_ff, dz_in;
   logic [16:0]        l_ff, l_in;
   logic [33:0]        sum_ff, sum_in;
   logic               accept;

   logic signed [31:0] xx, yy;
   logic signed [33:0] hh, dd;

   logic        sq_start, sq_done;
   logic [31:0] sq_root;

   assign full   = !((state_ff == F_IDLE) || ((state_ff == F_PUSH) && !q_full));
   assign accept = push && !full;
   assign q_push = (state_ff == F_PUSH) && !q_full;
   assign q_item = '{x: x_ff, y: y_ff, h: h_ff, dz: dz_ff, l: l_ff};

   assign xx = x_ff * x_ff;
   assign yy = y_ff * y_ff;
   assign hh = h_ff * h_ff;
   assign dd = dz_ff * dz_ff;

   assign sq_start = (state_ff == F_ROOT_R) || (state_ff == F_ROOT_L);

   lik_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_start (sq_start),
      .in_value ({30'b0, sum_ff}),
      .out_done (sq_done),
      .out_root (sq_root)
   );

   always_comb begin
      state_in = state_ff;
      sum_in   = sum_ff;
      h_in     = h_ff;
      dz_in    = dz_ff;
      l_in     = l_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_SUM_R;
            end
         end
         F_SUM_R: begin
            sum_in   = 34'($unsigned(xx)) + 34'($unsigned(yy));
            state_in = F_ROOT_R;
         end
         F_ROOT_R: begin
            state_in = F_WAIT_R;
         end
         F_WAIT_R: begin
            if (sq_done) begin
               h_in     = {1'b0, sq_root[15:0]} - {2'b0, cfg.coxa_offset_x};
               dz_in    = {z_ff[15], z_ff} - {cfg.coxa_offset_z[15], cfg.coxa_offset_z};
               state_in = F_SUM_L;
            end
         end
         F_SUM_L: begin
            sum_in   = $unsigned(hh) + $unsigned(dd);
            state_in = F_ROOT_L;
         end
         F_ROOT_L: begin
            state_in = F_WAIT_L;
         end
         F_WAIT_L: begin
            if (sq_done) begin
               l_in     = sq_root[16:0];
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = accept ? F_SUM_R : F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         x_ff <= target_x;
         y_ff <= target_y;
         z_ff <= target_z;
      end
      sum_ff <= sum_in;
      h_ff   <= h_in;
      dz_ff  <= dz_in;
      l_ff   <= l_in;
   end

endmodule

`default_nettype wire

@@ src/lik_back.sv @@
// ----------------------------------------------------------------------------
// lik_back
// Solves the joint angles of one queued item with a shared square-root unit
// and a shared CORDIC unit, and holds the finished result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module lik_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lik_pkg::leg_cfg_type  cfg,
   input  wire logic                  q_empty,
   input  wire lik_pkg::leg_item_type q_item,
   output logic                       q_pop,
   input  wire logic                  pop,
   output logic                       empty,
   output lik_pkg::leg_result_type    result
);
   import lik_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE, B_PROD, B_PREP, B_SQUARE, B_ROOT_GO, B_ROOT_WAIT, B_ACOS_GO,
      B_ACOS_WAIT, B_OMEGA_GO, B_OMEGA_WAIT, B_COXA_GO, B_COXA_WAIT, B_EMIT
   } state_type;

   state_type      state_ff, state_in;
   leg_item_type   item_ff;
   logic [29:0]    f2_ff, f2_in, t2_ff, t2_in, ft_ff, ft_in;
   logic [33:0]    l2_ff, l2_in;
   logic [31:0]    fl_ff, fl_in;
   logic           sel_ff, sel_in;      // 0: beta, 1: phi
   logic           flag_ff, flag_in;
   logic           neg_ff, neg_in;
   logic [29:0]    mag_ff, mag_in, den_ff, den_in;
   logic [59:0]    den2_ff, den2_in, mag2_ff, mag2_in;
   angle_type      beta_ff, beta_in, phi_ff, phi_in, omega_ff, omega_in;
   logic           valid_ff, valid_in;
   leg_result_type res_ff, res_in;

   logic signed [34:0] n_b, n_p, n_v;
   logic [33:0]        d_b, d_p, d_v, mag_full, mag_c;
   logic               skip, over;
   logic [2:0]         sh;
   logic               load, load_out;

   logic        sq_start, sq_done;
   logic [31:0] sq_root;
   logic        cd_start, cd_done;
   cord_type    cd_y, cd_x;
   angle_type   cd_angle;

   lik_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .in_start (sq_start),
      .in_value ({4'b0, den2_ff - mag2_ff}),
      .out_done (sq_done),
      .out_root (sq_root)
   );

   lik_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_start  (cd_start),
      .in_y      (cd_y),
      .in_x      (cd_x),
      .out_done  (cd_done),
      .out_angle (cd_angle)
   );

   assign sq_start = (state_ff == B_ROOT_GO);
   assign cd_start = (state_ff == B_ACOS_GO) || (state_ff == B_OMEGA_GO) ||
                     (state_ff == B_COXA_GO);

   always_comb begin
      case (state_ff)
         B_ACOS_GO: begin
            cd_y = {4'b0, sq_root[29:0]};
            cd_x = neg_ff ? -$signed({4'b0, mag_ff}) : $signed({4'b0, mag_ff});
         end
         B_OMEGA_GO: begin
            cd_y = 34'(item_ff.dz);
            cd_x = 34'(item_ff.h);
         end
         default: begin
            cd_y = 34'(item_ff.y);
            cd_x = 34'(item_ff.x);
         end
      endcase
   end

   // law-of-cosines numerator and denominator for both ratios
   always_comb begin
      n_b = $signed({5'b0, f2_ff}) + $signed({1'b0, l2_ff}) - $signed({5'b0, t2_ff});
      d_b = {1'b0, fl_ff, 1'b0};
      n_p = $signed({5'b0, f2_ff}) + $signed({5'b0, t2_ff}) - $signed({1'b0, l2_ff});
      d_p = {3'b0, ft_ff, 1'b0};
      n_v = sel_ff ? n_p : n_b;
      d_v = sel_ff ? d_p : d_b;
      if (sel_ff) begin
         skip = (cfg.femur_length == '0) || (cfg.tibia_length == '0);
      end else begin
         skip = (item_ff.l == '0) || (cfg.femur_length == '0);
      end
      mag_full = n_v[34] ? 34'(-n_v) : 34'(n_v);
      over     = mag_full > d_v;
      mag_c    = over ? d_v : mag_full;
      // bring the denominator below 2^30
      if (d_v[33]) begin
         sh = 3'd4;
      end else if (d_v[32]) begin
         sh = 3'd3;
      end else if (d_v[31]) begin
         sh = 3'd2;
      end else if (d_v[30]) begin
         sh = 3'd1;
      end else begin
         sh = 3'd0;
      end
   end

   assign load     = (state_ff == B_IDLE) && !q_empty;
   assign q_pop    = load;
   assign load_out = (state_ff == B_EMIT) && (!valid_ff || pop);

   always_comb begin
      state_in = state_ff;
      f2_in    = f2_ff;
      t2_in    = t2_ff;
      l2_in    = l2_ff;
      fl_in    = fl_ff;
      ft_in    = ft_ff;
      sel_in   = sel_ff;
      flag_in  = flag_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      den_in   = den_ff;
      den2_in  = den2_ff;
      mag2_in  = mag2_ff;
      beta_in  = beta_ff;
      phi_in   = phi_ff;
      omega_in = omega_ff;
      valid_in = valid_ff && !pop;
      res_in   = res_ff;
      case (state_ff)
         B_IDLE: begin
            if (load) begin
               sel_in   = 1'b0;
               flag_in  = 1'b0;
               state_in = B_PROD;
            end
         end
         B_PROD: begin
            f2_in    = cfg.femur_length * cfg.femur_length;
            t2_in    = cfg.tibia_length * cfg.tibia_length;
            ft_in    = cfg.femur_length * cfg.tibia_length;
            l2_in    = item_ff.l * item_ff.l;
            fl_in    = cfg.femur_length * item_ff.l;
            state_in = B_PREP;
         end
         B_PREP: begin
            if (skip) begin
               flag_in = 1'b1;
               if (sel_ff) begin
                  phi_in   = '0;
                  state_in = B_OMEGA_GO;
               end else begin
                  beta_in  = '0;
                  sel_in   = 1'b1;
                  state_in = B_PREP;
               end
            end else begin
               flag_in  = flag_ff || over;
               neg_in   = n_v[34];
               den_in   = 30'(d_v >> sh);
               mag_in   = 30'(mag_c >> sh);
               state_in = B_SQUARE;
            end
         end
         B_SQUARE: begin
            den2_in  = den_ff * den_ff;
            mag2_in  = mag_ff * mag_ff;
            state_in = B_ROOT_GO;
         end
         B_ROOT_GO: begin
            state_in = B_ROOT_WAIT;
         end
         B_ROOT_WAIT: begin
            if (sq_done) begin
               state_in = B_ACOS_GO;
            end
         end
         B_ACOS_GO: begin
            state_in = B_ACOS_WAIT;
         end
         B_ACOS_WAIT: begin
            if (cd_done) begin
               if (sel_ff) begin
                  phi_in   = cd_angle;
                  state_in = B_OMEGA_GO;
               end else begin
                  beta_in  = cd_angle;
                  sel_in   = 1'b1;
                  state_in = B_PREP;
               end
            end
         end
         B_OMEGA_GO: begin
            state_in = B_OMEGA_WAIT;
         end
         B_OMEGA_WAIT: begin
            if (cd_done) begin
               omega_in = cd_angle;
               state_in = B_COXA_GO;
            end
         end
         B_COXA_GO: begin
            state_in = B_COXA_WAIT;
         end
         B_COXA_WAIT: begin
            if (cd_done) begin
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (load_out) begin
               res_in.coxa_angle   = to_q12(cd_angle);
               res_in.femur_angle  = to_q12(beta_ff + omega_ff);
               res_in.tibia_angle  = to_q12(PI_Q30 + phi_ff);
               res_in.out_of_reach = flag_ff;
               valid_in            = 1'b1;
               state_in            = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
         flag_ff  <= flag_in;
      end
      if (load) begin
         item_ff <= q_item;
      end
      f2_ff    <= f2_in;
      t2_ff    <= t2_in;
      l2_ff    <= l2_in;
      fl_ff    <= fl_in;
      ft_ff    <= ft_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      den_ff   <= den_in;
      den2_ff  <= den2_in;
      mag2_ff  <= mag2_in;
      beta_ff  <= beta_in;
      phi_ff   <= phi_in;
      omega_ff <= omega_in;
      res_ff   <= res_in;
   end

   assign empty  = !valid_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

@@ src/leg_inverse_kinematics_core.sv @@
// ----------------------------------------------------------------------------
// leg_inverse_kinematics_core
// Three-link leg inverse kinematics: foot target in Q12.4 mm to coxa, femur
// and tibia angles in Q4.12 radians.
// ----------------------------------------------------------------------------
// The front end takes a request, computes the radial reach and the reach
// distance with a square-root unit and hands the result through a two-entry
// queue to the back end. The back end shares one square-root unit and one
// 16-step CORDIC unit across both acos terms and both atan2 terms, and its
// solve time sets the sustained rate. Front and back run concurrently, and a
// finished result waits in an output register while the next request is
// solved. Geometry registers are written over the APB port; the user must
// write them only while idle, since the block itself does not enforce it.
`default_nettype none

module leg_inverse_kinematics_core (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               push,
   output logic                    full,
   input  wire logic signed [15:0] req_target_x,
   input  wire logic signed [15:0] req_target_y,
   input  wire logic signed [15:0] req_target_z,
   // result channel
   output logic                    empty,
   input  wire logic               pop,
   output logic signed [15:0]      rsp_coxa_angle,
   output logic signed [15:0]      rsp_femur_angle,
   output logic signed [15:0]      rsp_tibia_angle,
   output logic                    rsp_out_of_reach,
   // configuration
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [3:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import lik_pkg::*;

   localparam logic [1:0] REG_COXA_X = 2'd0;
   localparam logic [1:0] REG_COXA_Z = 2'd1;
   localparam logic [1:0] REG_FEMUR  = 2'd2;
   localparam logic [1:0] REG_TIBIA  = 2'd3;

   logic [14:0]        cox_ff, fem_ff, tib_ff;
   logic signed [15:0] coz_ff;
   logic               wr_en;
   leg_cfg_type        cfg;

   logic           q_push, q_full, q_empty, q_pop;
   leg_item_type   q_in, q_out;
   leg_result_type result;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cox_ff <= 15'd719;
         coz_ff <= 16'sd170;
         fem_ff <= 15'd1893;
         tib_ff <= 15'd3543;
      end else if (wr_en) begin
         case (paddr[3:2])
            REG_COXA_X: cox_ff <= pwdata[14:0];
            REG_COXA_Z: coz_ff <= pwdata[15:0];
            REG_FEMUR:  fem_ff <= pwdata[14:0];
            REG_TIBIA:  tib_ff <= pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_COXA_X: prdata = {17'b0, cox_ff};
         REG_COXA_Z: prdata = {16'b0, coz_ff};
         REG_FEMUR:  prdata = {17'b0, fem_ff};
         REG_TIBIA:  prdata = {17'b0, tib_ff};
         default:    prdata = '0;
      endcase
   end

   assign cfg = '{coxa_offset_x: cox_ff, coxa_offset_z: coz_ff,
                  femur_length: fem_ff, tibia_length: tib_ff};

   lik_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .push     (push),
      .full     (full),
      .target_x (req_target_x),
      .target_y (req_target_y),
      .target_z (req_target_z),
      .q_push   (q_push),
      .q_item   (q_in),
      .q_full   (q_full)
   );

   lik_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_push   (q_push),
      .in_item   (q_in),
      .in_pop    (q_pop),
      .out_full  (q_full),
      .out_empty (q_empty),
      .out_item  (q_out)
   );

   lik_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .q_item  (q_out),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .result  (result)
   );

   assign rsp_coxa_angle   = result.coxa_angle;
   assign rsp_femur_angle  = result.femur_angle;
   assign rsp_tibia_angle  = result.tibia_angle;
   assign rsp_out_of_reach = result.out_of_reach;

endmodule

`default_nettype wire

@@ tb/lik_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// lik_tb_pkg
// Register map of the leg IK core as seen from the verification side.
// ----------------------------------------------------------------------------
package lik_tb_pkg;

   typedef enum logic [1:0] {
      REG_COXA_X = 2'd0,
      REG_COXA_Z = 2'd1,
      REG_FEMUR  = 2'd2,
      REG_TIBIA  = 2'd3
   } leg_reg_type;

endpackage

@@ tb/leg_ik_checker.sv @@
// ----------------------------------------------------------------------------
// leg_ik_checker
// Watches the request, result and register ports of the leg IK core,
// computes the expected joint angles per request and compares them in order.
// ----------------------------------------------------------------------------
module leg_ik_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               full,
   input  logic signed [15:0] req_target_x,
   input  logic signed [15:0] req_target_y,
   input  logic signed [15:0] req_target_z,
   input  logic               empty,
   input  logic               pop,
   input  logic signed [15:0] rsp_coxa_angle,
   input  logic signed [15:0] rsp_femur_angle,
   input  logic signed [15:0] rsp_tibia_angle,
   input  logic               rsp_out_of_reach,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic               pready,
   output int                 pending,
   output int                 failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import lik_pkg::*;
   import lik_tb_pkg::*;

   localparam longint PI_RAD = 64'sd3373259426;
   localparam longint ARCTAN [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

   logic [14:0]        geo_ox;
   logic signed [15:0] geo_oz;
   logic [14:0]        geo_femur;
   logic [14:0]        geo_tibia;

   leg_result_type angles_due[$];

   function automatic longint root_floor(longint unsigned v);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
         if (v >= res + bit_v) begin
            v -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return longint'(res);
   endfunction

   // vectoring rotation, result in Q.30 radians
   function automatic longint arc_tan2(longint y, longint x);
      longint z, m, ax, ay, tx, ty;
      int k;
      z = 0;
      k = 0;
      if (y == 0) return (x < 0) ? PI_RAD : 0;
      if (x < 0) begin
         z = (y > 0) ? PI_RAD : -PI_RAD;
         x = -x;
         y = -y;
      end
      ax = x;
      ay = (y < 0) ? -y : y;
      m = (ax > ay) ? ax : ay;
      while ((m >> k) >= (64'sd1 << 31)) k++;
      if (k > 0) begin
         x = x >>> k;
         y = y >>> k;
      end else begin
         while (m < (64'sd1 << 29)) begin
            x *= 2;
            y *= 2;
            m *= 2;
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         tx = x >>> i;
         ty = y >>> i;
         if (y >= 0) begin
            x += ty;
            y -= tx;
            z += ARCTAN[i];
         end else begin
            x -= ty;
            y += tx;
            z -= ARCTAN[i];
         end
      end
      return z;
   endfunction

   // acos(n/d) as atan2(sqrt(d^2-n^2), n), clamped
   function automatic longint arc_cos_ratio(longint n, longint d, inout bit clamped);
      bit neg;
      longint mag, den, s;
      neg = n < 0;
      mag = neg ? -n : n;
      den = d;
      if (mag > den) begin
         mag = den;
         clamped = 1;
      end
      while (den >= (64'sd1 << 30)) begin
         den >>= 1;
         mag >>= 1;
      end
      s = root_floor(longint'(den * den - mag * mag));
      return arc_tan2(s, neg ? -mag : mag);
   endfunction

   function automatic logic signed [15:0] rad_q12(longint a);
      longint s;
      s = (a + (64'sd1 << 17)) >>> 18;
      return s[15:0];
   endfunction

   function automatic leg_result_type solve_leg(longint x, longint y, longint z);
      leg_result_type res;
      longint f, t, dz, r, h, l, omega, beta, phi;
      bit clamped;
      f = longint'(geo_femur);
      t = longint'(geo_tibia);
      dz = z - longint'(geo_oz);
      r = root_floor(x * x + y * y);
      h = r - longint'(geo_ox);
      l = root_floor(h * h + dz * dz);
      beta = 0;
      phi = 0;
      clamped = 0;
      omega = arc_tan2(dz, h);
      if (l == 0 || f == 0) clamped = 1;
      else beta = arc_cos_ratio(f * f + l * l - t * t, 2 * f * l, clamped);
      if (f == 0 || t == 0) clamped = 1;
      else phi = arc_cos_ratio(f * f + t * t - l * l, 2 * f * t, clamped);
      res.coxa_angle   = rad_q12(arc_tan2(y, x));
      res.femur_angle  = rad_q12(beta + omega);
      res.tibia_angle  = rad_q12(PI_RAD + phi);
      res.out_of_reach = clamped;
      return res;
   endfunction

   assign pending = angles_due.size();

   always @(posedge clock) begin
      leg_result_type want;
      if (reset) begin
         geo_ox    <= 15'd719;
         geo_oz    <= 16'sd170;
         geo_femur <= 15'd1893;
         geo_tibia <= 15'd3543;
         angles_due.delete();
         failures = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (leg_reg_type'(paddr[3:2]))
               REG_COXA_X: geo_ox    <= pwdata[14:0];
               REG_COXA_Z: geo_oz    <= pwdata[15:0];
               REG_FEMUR:  geo_femur <= pwdata[14:0];
               REG_TIBIA:  geo_tibia <= pwdata[14:0];
               default: begin
               end
            endcase
         end
         if (push && !full)
            angles_due.push_back(solve_leg(req_target_x, req_target_y, req_target_z));
         if (pop && !empty) begin
            if (angles_due.size() == 0) begin
               failures++;
               if (failures <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
               want = angles_due.pop_front();
               if (want.coxa_angle !== rsp_coxa_angle ||
                   want.femur_angle !== rsp_femur_angle ||
                   want.tibia_angle !== rsp_tibia_angle ||
                   want.out_of_reach !== rsp_out_of_reach) begin
                  failures++;
                  if (failures <= 10)
                     $display("mismatch at %0t: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                        $realtime, want.coxa_angle, want.femur_angle,
                        want.tibia_angle, want.out_of_reach, rsp_coxa_angle,
                        rsp_femur_angle, rsp_tibia_angle, rsp_out_of_reach);
               end
            end
         end
      end
   end

endmodule

@@ tb/leg_inverse_kinematics_core_tb.sv @@
// ----------------------------------------------------------------------------
// leg_inverse_kinematics_core_tb
// Drives foot targets under several leg geometries with random gaps and
// back-pressure; a checker beside the core predicts and compares the angles.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lik_tb_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               push = 0;
   logic               full;
   logic signed [15:0] req_target_x = 0;
   logic signed [15:0] req_target_y = 0;
   logic signed [15:0] req_target_z = 0;
   logic               empty;
   logic               pop = 0;
   logic signed [15:0] rsp_coxa_angle;
   logic signed [15:0] rsp_femur_angle;
   logic signed [15:0] rsp_tibia_angle;
   logic               rsp_out_of_reach;
   logic               psel = 0;
   logic               penable = 0;
   logic               pwrite = 0;
   logic [3:0]         paddr = 0;
   logic [31:0]        pwdata = 0;
   logic [31:0]        prdata;
   logic               pready;
   int                 pending;
   int                 failures;
   bit                 steady = 0;
   bit                 hold_off = 0;

   leg_inverse_kinematics_core uut (.*);

   leg_ik_checker u_checker (.*);

   always #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("leg_inverse_kinematics_core_tb NOT OK");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            pop <= 0;
            repeat (1500) @(posedge clock);
            hold_off = 0;
         end else begin
            pop <= steady || ($urandom_range(0, 99) >= 24);
         end
      end
   end

   task automatic write_reg(leg_reg_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic send_target(int x, int y, int z);
      if (!steady && $urandom_range(0, 99) < 24) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_target_x <= 16'(x);
      req_target_y <= 16'(y);
      req_target_z <= 16'(z);
      do @(posedge clock); while (full);
   endtask

   task automatic drain;
      push <= 0;
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic set_geometry(int ox, int oz, int f, int t);
      write_reg(REG_COXA_X, ox);
      write_reg(REG_COXA_Z, oz);
      write_reg(REG_FEMUR, f);
      write_reg(REG_TIBIA, t);
   endtask

   task automatic random_targets(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 60)
            send_target($urandom_range(0, 12000) - 6000, $urandom_range(0, 12000) - 6000,
                        $urandom_range(0, 8000) - 4000);
         else
            send_target($urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // corners, axes and degenerate geometry under reset values
      send_target(0, 0, 0);
      send_target(16'h8000, 16'h8000, 16'h8000);
      send_target(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_target(16'h8000, 16'h7FFF, 16'h8000);
      send_target(16'h7FFF, 16'h8000, 16'h7FFF);
      send_target(-1000, 0, 0);
      send_target(3000, 0, 170);
      send_target(0, 2000, -500);
      send_target(0, -2000, 500);
      send_target(719, 0, 170);          // zero reach
      send_target(719 + 5436, 0, 170);   // fully stretched
      send_target(719 + 1650, 0, 170);   // fully folded at minimum reach
      send_target(-16'sd1, -16'sd1, 16'h0001);
      send_target(2500, 1500, -2000);
      send_target(-2500, -1500, 2500);
      send_target(16'h5555, 16'hAAAA, 16'h5555);
      send_target(16'hAAAA, 16'h5555, 16'hAAAA);
      random_targets(120);
      drain();

      set_geometry(15'd0, 16'h8000, 15'd1, 15'd1);
      send_target(0, 0, 16'h8000);       // zero reach at the extremes
      hold_off = 1;
      random_targets(130);
      drain();

      set_geometry(15'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF);
      steady = 1;
      random_targets(130);
      steady = 0;
      drain();

      set_geometry($urandom_range(0, 2000), $urandom_range(0, 4000) - 2000,
                   $urandom_range(1, 6000), $urandom_range(1, 6000));
      random_targets(140);
      drain();

      set_geometry(15'd719, 16'd170, 15'd1893, 15'd3543);
      random_targets(140);
      drain();

      if (failures == 0)
         $display("leg_inverse_kinematics_core_tb OK");
      else
         $display("leg_inverse_kinematics_core_tb NOT OK");
      $finish;
   end

endmodule
